// ----- src/dq_pkg.sv -----
// Shared types and constants for the double-ended queue core.
`default_nettype none
package dq_pkg;

  localparam int OPCODE_W = 3;
  localparam int ENTRY_W  = 64;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // Stream packing widths
  localparam int IN_TDATA_W  = 64;
  localparam int IN_TUSER_W  = 8;
  localparam int OUT_TDATA_W = 72;

  // Input opcodes
  localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_LIST       = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  // Command queue between front and back
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = 1;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT,
    CMD_PUSH_BACK,
    CMD_POP_FRONT,
    CMD_POP_BACK,
    CMD_LIST
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic [ENTRY_W-1:0]   entry;
  } cmd_t;

endpackage
`default_nettype wire

// ----- src/dq_front.sv -----
// Front end: accepts input transactions, decodes opcodes, queues commands.
`default_nettype none
module dq_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [dq_pkg::IN_TDATA_W-1:0] s_tdata,  // [63:0] entry_in
  input  wire logic [dq_pkg::IN_TUSER_W-1:0] s_tuser,  // [2:0] opcode, rest zero
  output logic                               cmd_valid,
  input  wire logic                          cmd_ready,
  output dq_pkg::cmd_t                       cmd
);

  dq_pkg::cmd_t                   q [dq_pkg::CMDQ_DEPTH];
  logic [dq_pkg::CMDQ_AW-1:0]     wr_ptr;
  logic [dq_pkg::CMDQ_AW-1:0]     rd_ptr;
  logic [dq_pkg::CMDQ_AW:0]       fill;
  logic                           accept;
  logic                           known_op;
  logic                           enq;
  logic                           deq;
  dq_pkg::cmd_t                   dec;

  always_comb begin
    known_op  = 1'b1;
    dec.entry = s_tdata[dq_pkg::ENTRY_W-1:0];
    dec.kind  = dq_pkg::CMD_LIST;
    case (s_tuser[dq_pkg::OPCODE_W-1:0])
      dq_pkg::OP_PUSH_FRONT: dec.kind = dq_pkg::CMD_PUSH_FRONT;
      dq_pkg::OP_PUSH_BACK:  dec.kind = dq_pkg::CMD_PUSH_BACK;
      dq_pkg::OP_POP_FRONT:  dec.kind = dq_pkg::CMD_POP_FRONT;
      dq_pkg::OP_POP_BACK:   dec.kind = dq_pkg::CMD_POP_BACK;
      dq_pkg::OP_LIST:       dec.kind = dq_pkg::CMD_LIST;
      default:               known_op = 1'b0;  // undefined opcodes are dropped
    endcase
  end

  assign s_tready  = (fill != (dq_pkg::CMDQ_AW+1)'(dq_pkg::CMDQ_DEPTH));
  assign accept    = s_tvalid && s_tready;
  assign enq       = accept && known_op;
  assign cmd_valid = (fill != '0);
  assign deq       = cmd_valid && cmd_ready;
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (enq) begin
      q[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (enq) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (deq) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({enq, deq})
        2'b10:   fill <= fill + (dq_pkg::CMDQ_AW+1)'(1);
        2'b01:   fill <= fill - (dq_pkg::CMDQ_AW+1)'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- src/dq_back.sv -----
// Back end: executes queue commands against the ring store, registers results.
`default_nettype none
module dq_back #(
  parameter int DEPTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cmd_valid,
  output logic                                  cmd_ready,
  input  wire dq_pkg::cmd_t                     cmd,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [dq_pkg::STATUS_W-1:0]           out_status,
  output logic [dq_pkg::ENTRY_W-1:0]            out_entry,
  output logic [dq_pkg::COUNT_W-1:0]            out_count,
  output logic                                  out_last
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_LIST
  } state_t;

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i);
    return (i == AW'(DEPTH - 1)) ? '0 : i + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] i);
    return (i == '0) ? AW'(DEPTH - 1) : i - AW'(1);
  endfunction

  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  logic [dq_pkg::ENTRY_W-1:0] mem [DEPTH];
  logic [dq_pkg::ENTRY_W-1:0] rd_data;

  state_t         state, state_next;
  logic [AW-1:0]  front, front_next;
  logic [CW-1:0]  held, held_next;
  logic [CW-1:0]  cursor, cursor_next;
  logic [AW-1:0]  list_pos, list_pos_next;

  logic           out_free;
  logic           full;
  logic           empty;
  logic           rd_en;
  logic [AW-1:0]  rd_addr;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic           emit;
  logic [dq_pkg::STATUS_W-1:0] e_status;
  logic [dq_pkg::ENTRY_W-1:0]  e_entry;
  logic [dq_pkg::COUNT_W-1:0]  e_count;
  logic                        e_last;

  assign out_free  = !m_tvalid || m_tready;
  assign full      = (held == CW'(DEPTH));
  assign empty     = (held == '0);
  assign cmd_ready = (state == ST_IDLE) && out_free;

  always_comb begin
    state_next    = state;
    front_next    = front;
    held_next     = held;
    cursor_next   = cursor;
    list_pos_next = list_pos;
    rd_en         = 1'b0;
    rd_addr       = front;
    wr_en         = 1'b0;
    wr_addr       = front;
    emit          = 1'b0;
    e_status      = dq_pkg::STATUS_OK;
    e_entry       = '0;
    e_count       = dq_pkg::COUNT_W'(held);
    e_last        = 1'b1;
    case (state)
      ST_IDLE: begin
        if (cmd_valid && out_free) begin
          case (cmd.kind)
            dq_pkg::CMD_PUSH_FRONT, dq_pkg::CMD_PUSH_BACK: begin
              emit = 1'b1;
              if (full) begin
                e_status = dq_pkg::STATUS_FULL;
              end else begin
                wr_en = 1'b1;
                if (cmd.kind == dq_pkg::CMD_PUSH_FRONT) begin
                  wr_addr    = ring_prev(front);
                  front_next = ring_prev(front);
                end else begin
                  wr_addr = ring_add(front, held);
                end
                held_next = held + CW'(1);
                e_count   = dq_pkg::COUNT_W'(held + CW'(1));
              end
            end
            dq_pkg::CMD_POP_FRONT, dq_pkg::CMD_POP_BACK: begin
              if (empty) begin
                emit     = 1'b1;
                e_status = dq_pkg::STATUS_EMPTY;
              end else begin
                rd_en = 1'b1;
                if (cmd.kind == dq_pkg::CMD_POP_FRONT) begin
                  rd_addr    = front;
                  front_next = ring_next(front);
                end else begin
                  rd_addr = ring_add(front, held - CW'(1));
                end
                held_next  = held - CW'(1);
                state_next = ST_POP;
              end
            end
            dq_pkg::CMD_LIST: begin
              if (empty) begin
                emit     = 1'b1;
                e_status = dq_pkg::STATUS_EMPTY;
              end else begin
                rd_en         = 1'b1;
                rd_addr       = front;
                list_pos_next = front;
                cursor_next   = '0;
                state_next    = ST_LIST;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_POP: begin
        if (out_free) begin
          emit       = 1'b1;
          e_entry    = rd_data;
          state_next = ST_IDLE;
        end
      end
      ST_LIST: begin
        if (out_free) begin
          emit    = 1'b1;
          e_entry = rd_data;
          e_last  = (cursor + CW'(1) == held);
          if (e_last) begin
            cursor_next = '0;
            state_next  = ST_IDLE;
          end else begin
            // prefetch the next ring slot while this one is presented
            rd_en         = 1'b1;
            rd_addr       = ring_next(list_pos);
            list_pos_next = ring_next(list_pos);
            cursor_next   = cursor + CW'(1);
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Ring store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= cmd.entry;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      front    <= '0;
      held     <= '0;
      cursor   <= '0;
      list_pos <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      front    <= front_next;
      held     <= held_next;
      cursor   <= cursor_next;
      list_pos <= list_pos_next;
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_status <= e_status;
      out_entry  <= e_entry;
      out_count  <= e_count;
      out_last   <= e_last;
    end
  end

endmodule
`default_nettype wire

// ----- src/double_ended_queue_core.sv -----
// Top level of the bounded double-ended queue core.
// Push results are registered from the command; pop results also pass the registered ring read.
// A list of N entries yields N results, one per cycle unless the output stalls; an empty list one.
// One push per cycle unless the output stalls; a pop or list holds the back end until it is done.
// A two-entry command queue lets the input side keep accepting while the back end is busy.
// Synchronous active-high reset empties the queue; ring contents are not cleared.
`default_nettype none
module double_ended_queue_core #(
  parameter int DEPTH = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [dq_pkg::IN_TDATA_W-1:0]  s_tdata,  // [63:0] entry_in
  input  wire logic [dq_pkg::IN_TUSER_W-1:0]  s_tuser,  // [2:0] opcode
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [dq_pkg::OUT_TDATA_W-1:0]      m_tdata,  // [1:0] status, [65:2] entry_out,
                                                        // [70:66] entry_count, [71] zero
  output logic                                m_tlast   // last_result
);

  logic                          cmd_valid;
  logic                          cmd_ready;
  dq_pkg::cmd_t                  cmd;
  logic [dq_pkg::STATUS_W-1:0]   out_status;
  logic [dq_pkg::ENTRY_W-1:0]    out_entry;
  logic [dq_pkg::COUNT_W-1:0]    out_count;

  dq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  dq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .out_status (out_status),
    .out_entry  (out_entry),
    .out_count  (out_count),
    .out_last   (m_tlast)
  );

  assign m_tdata = {1'b0, out_count, out_entry, out_status};

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking stream testbench for double_ended_queue_core with a built-in deque predictor.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;
  localparam int RANDOM_ITEMS = 150;
  localparam int REPORT_LIMIT = 10;

  typedef logic [dq_pkg::OPCODE_W-1:0] opcode_t;
  typedef logic [dq_pkg::COUNT_W-1:0]  count_t;

  // Opcodes the core must ignore
  localparam opcode_t OP_UNUSED_FIRST = 3'd5;
  localparam opcode_t OP_UNUSED_LAST  = 3'd7;

  typedef struct packed {
    logic [dq_pkg::STATUS_W-1:0] status;
    logic [dq_pkg::ENTRY_W-1:0]  entry;
    logic [dq_pkg::COUNT_W-1:0]  count;
    logic                        last;
  } deque_result_t;

  typedef struct {
    opcode_t                    op;
    logic [dq_pkg::ENTRY_W-1:0] entry;
    bit                         hold_for_drain;
  } deque_cmd_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [dq_pkg::IN_TDATA_W-1:0] s_tdata = '0;
  logic [dq_pkg::IN_TUSER_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [dq_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic m_tlast;

  double_ended_queue_core #(.DEPTH(DEPTH)) DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast)
  );

  // Predictor state: ring contents, front position, occupancy
  logic [dq_pkg::ENTRY_W-1:0] ring [DEPTH];
  int head = 0;
  int held = 0;

  deque_cmd_t    cmd_stream [$];
  deque_result_t results_due [$];
  deque_cmd_t    next_cmd;
  deque_result_t got, want;

  int planned_cmds = 1;
  int cmds_accepted = 0;
  int results_checked = 0;
  int failures = 0;
  int full_refusals = 0;
  int empty_hits = 0;
  int longest_list = 0;
  int send_idle = 17;
  int recv_idle = 68;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("** double_ended_queue_core: FAILED **");
    $finish;
  end

  function automatic void note_failure(string msg);
    failures++;
    if (failures <= REPORT_LIMIT) $display("ERROR: %s", msg);
  endfunction

  // Work out the results one command causes and advance the deque state.
  task automatic apply_deque_op(input opcode_t op, input logic [dq_pkg::ENTRY_W-1:0] word);
    deque_result_t r;
    int pos;
    r = '0;
    r.last = 1'b1;
    case (op)
      dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_BACK: begin
        if (held == DEPTH) begin
          r.status = dq_pkg::STATUS_FULL;
          r.count = count_t'(held);
          full_refusals++;
        end else begin
          if (op == dq_pkg::OP_PUSH_FRONT) begin
            head = (head == 0) ? DEPTH - 1 : head - 1;
            ring[head] = word;
          end else begin
            ring[(head + held) % DEPTH] = word;
          end
          held++;
          r.status = dq_pkg::STATUS_OK;
          r.count = count_t'(held);
        end
        results_due.push_back(r);
      end
      dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_BACK: begin
        if (held == 0) begin
          r.status = dq_pkg::STATUS_EMPTY;
          empty_hits++;
        end else begin
          if (op == dq_pkg::OP_POP_FRONT) begin
            r.entry = ring[head];
            head = (head + 1) % DEPTH;
          end else begin
            r.entry = ring[(head + held - 1) % DEPTH];
          end
          held--;
          r.status = dq_pkg::STATUS_OK;
          r.count = count_t'(held);
        end
        results_due.push_back(r);
      end
      dq_pkg::OP_LIST: begin
        if (held == 0) begin
          r.status = dq_pkg::STATUS_EMPTY;
          empty_hits++;
          results_due.push_back(r);
        end else begin
          if (held > longest_list) longest_list = held;
          pos = head;
          for (int k = 0; k < held; k++) begin
            r.status = dq_pkg::STATUS_OK;
            r.entry = ring[pos];
            r.count = count_t'(held);
            r.last = (k == held - 1);
            results_due.push_back(r);
            pos = (pos + 1) % DEPTH;
          end
        end
      end
      default: ;  // unused opcodes: no result, no state change
    endcase
  endtask

  function automatic logic [dq_pkg::ENTRY_W-1:0] pick_word();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic add_cmd(input opcode_t op, input logic [dq_pkg::ENTRY_W-1:0] word,
                         input bit hold);
    deque_cmd_t c;
    c.op = op;
    c.entry = word;
    c.hold_for_drain = hold;
    cmd_stream.push_back(c);
  endtask

  // Driver: predicts each accepted transaction, then decides what to present next.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        apply_deque_op(s_tuser[dq_pkg::OPCODE_W-1:0], s_tdata);
        cmds_accepted++;
        case (cmds_accepted * 3 / planned_cmds)
          0: begin
            send_idle = 17;
            recv_idle = 68;
          end
          1: begin
            send_idle = 68;
            recv_idle = 17;
          end
          default: begin
            send_idle = 0;
            recv_idle = 0;
          end
        endcase
      end
      if (!s_tvalid || s_tready) begin
        if (cmd_stream.size() != 0 &&
            !(cmd_stream[0].hold_for_drain && results_due.size() != 0) &&
            $urandom_range(99) >= send_idle) begin
          next_cmd = cmd_stream.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= next_cmd.entry;
          s_tuser <= {{(dq_pkg::IN_TUSER_W - dq_pkg::OPCODE_W){1'b0}}, next_cmd.op};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random backpressure, compare each result with the oldest one due.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle);
      if (m_tvalid && m_tready) begin
        got.status = m_tdata[dq_pkg::STATUS_W-1:0];
        got.entry = m_tdata[dq_pkg::STATUS_W +: dq_pkg::ENTRY_W];
        got.count = m_tdata[dq_pkg::STATUS_W + dq_pkg::ENTRY_W +: dq_pkg::COUNT_W];
        got.last = m_tlast;
        if (results_due.size() == 0) begin
          note_failure($sformatf("unexpected result: status %0d entry %h count %0d last %b",
                                 got.status, got.entry, got.count, got.last));
        end else begin
          want = results_due.pop_front();
          results_checked++;
          if (got !== want || m_tdata[dq_pkg::OUT_TDATA_W-1] !== 1'b0) begin
            note_failure($sformatf(
              {"result %0d: expected status %0d entry %h count %0d last %b, ",
               "got status %0d entry %h count %0d last %b pad %b"},
              results_checked, want.status, want.entry, want.count, want.last,
              got.status, got.entry, got.count, got.last, m_tdata[dq_pkg::OUT_TDATA_W-1]));
          end
        end
      end
    end
  end

  initial begin
    int n;
    int mode;
    int run;
    int pick;
    bit hold_done;
    opcode_t op;

    // Directed: empty cases, ignored opcodes, fill to full, refused push, full list, pops at both ends
    add_cmd(dq_pkg::OP_LIST, '0, 1'b0);
    add_cmd(dq_pkg::OP_POP_FRONT, '1, 1'b0);
    add_cmd(dq_pkg::OP_POP_BACK, '0, 1'b0);
    for (int k = OP_UNUSED_FIRST; k <= OP_UNUSED_LAST; k++) add_cmd(opcode_t'(k), '1, 1'b0);
    for (int k = 0; k < DEPTH; k++) begin
      case (k % 4)
        0: add_cmd(dq_pkg::OP_PUSH_FRONT, '0, 1'b0);
        1: add_cmd(dq_pkg::OP_PUSH_BACK, '1, 1'b0);
        2: add_cmd(dq_pkg::OP_PUSH_FRONT, {32{2'b10}}, 1'b0);
        default: add_cmd(dq_pkg::OP_PUSH_BACK, {$urandom, $urandom}, 1'b0);
      endcase
    end
    add_cmd(dq_pkg::OP_PUSH_BACK, {32{2'b01}}, 1'b0);
    add_cmd(dq_pkg::OP_LIST, '0, 1'b0);
    add_cmd(dq_pkg::OP_POP_FRONT, '0, 1'b0);
    add_cmd(dq_pkg::OP_POP_BACK, '1, 1'b0);

    // Random: runs biased toward filling, draining or balanced traffic
    n = 0;
    hold_done = 1'b0;
    while (n < RANDOM_ITEMS) begin
      mode = $urandom_range(2);
      run = $urandom_range(20, 6);
      repeat (run) begin
        pick = $urandom_range(99);
        if (pick < 3) begin
          op = opcode_t'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
        end else if (pick < 12) begin
          op = dq_pkg::OP_LIST;
        end else begin
          pick = $urandom_range(99);
          if ((mode == 0 && pick < 75) || (mode == 1 && pick < 30) ||
              (mode == 2 && pick < 55)) begin
            op = $urandom_range(1) ? dq_pkg::OP_PUSH_FRONT : dq_pkg::OP_PUSH_BACK;
          end else begin
            op = $urandom_range(1) ? dq_pkg::OP_POP_FRONT : dq_pkg::OP_POP_BACK;
          end
        end
        add_cmd(op, pick_word(), !hold_done && n >= RANDOM_ITEMS / 2);
        if (n >= RANDOM_ITEMS / 2) hold_done = 1'b1;
        if (op < OP_UNUSED_FIRST) n++;
      end
    end
    planned_cmds = cmd_stream.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (cmd_stream.size() != 0 || s_tvalid) @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Sent %0d commands, checked %0d results: %0d refused pushes, %0d empty pops/lists,",
             cmds_accepted, results_checked, full_refusals, empty_hits);
    $display("longest list %0d entries, %0d mismatches.", longest_list, failures);
    if (failures == 0) begin
      $display("** double_ended_queue_core: PASSED **");
    end else begin
      $display("** double_ended_queue_core: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire
